### hw/rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants for the run-length byte decoder: header
// classes, the decode mode, and the item that moves from front to back.
// ----------------------------------------------------------------------------
package prd_pkg;

   // Header bytes above this value announce a repeated byte
   localparam logic [7:0]  HEADER_SPLIT  = 8'h80;
   // Repeat count is this value minus the header
   localparam logic [8:0]  REPEAT_BASE   = 9'd257;
   // Reset value of the output limit register
   localparam logic [15:0] LIMIT_RESET   = 16'd64000;
   localparam int          LIMIT_WIDTH   = 16;
   localparam int          BYTE_WIDTH    = 8;
   // Queue between front and back
   localparam int          QUEUE_DEPTH   = 2;
   localparam int          QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_REPEAT  = 2'd1,
      MODE_LITERAL = 2'd2
   } prd_mode_type;

   // One queued item: a data byte with its run length, or a start token
   typedef struct packed {
      logic                  is_data;
      logic [BYTE_WIDTH-1:0] value;
      logic [BYTE_WIDTH-1:0] run;
   } prd_entry_type;

endpackage

### hw/rtl/prd_front.sv
// ----------------------------------------------------------------------------
// prd_front
// Front end: accepts compressed bytes, tracks the header / data framing and
// pushes data bytes (with run length) and start tokens into the queue.
// ----------------------------------------------------------------------------
module prd_front
   import prd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_stream_byte,
   input  logic          req_start_image,
   input  logic          q_ready,
   output logic          q_push,
   output prd_entry_type q_entry
);

   prd_mode_type mode_ff, mode_in;
   logic [7:0]   lit_left_ff, lit_left_in;
   logic [7:0]   pend_ff, pend_in;
   logic         accept;
   prd_mode_type eff_mode;
   logic [7:0]   lit_dec;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   // a start marker always makes this byte a header
   assign eff_mode  = req_start_image ? MODE_HEADER : mode_ff;
   assign lit_dec   = lit_left_ff - 8'd1;

   // Next state
   always_comb begin
      mode_in     = mode_ff;
      lit_left_in = lit_left_ff;
      pend_in     = pend_ff;
      if (accept) begin
         case (eff_mode)
            MODE_REPEAT: begin
               mode_in = MODE_HEADER;
            end
            MODE_LITERAL: begin
               lit_left_in = lit_dec;
               if (lit_dec == 8'd0) begin
                  mode_in = MODE_HEADER;
               end
            end
            default: begin
               if (req_stream_byte > HEADER_SPLIT) begin
                  pend_in = 8'(REPEAT_BASE - {1'b0, req_stream_byte});
                  mode_in = MODE_REPEAT;
               end else begin
                  lit_left_in = req_stream_byte + 8'd1;
                  mode_in     = MODE_LITERAL;
               end
            end
         endcase
      end
   end

   // Queue outputs
   always_comb begin
      q_push          = 1'b0;
      q_entry.is_data = 1'b0;
      q_entry.value   = req_stream_byte;
      q_entry.run     = 8'd1;
      case (eff_mode)
         MODE_REPEAT: begin
            q_push          = accept;
            q_entry.is_data = 1'b1;
            q_entry.run     = pend_ff;
         end
         MODE_LITERAL: begin
            q_push          = accept;
            q_entry.is_data = 1'b1;
         end
         default: begin
            // header: only a start marker goes on to the back end
            q_push = accept && req_start_image;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HEADER;
         lit_left_ff <= 8'd0;
         pend_ff     <= 8'd0;
      end else begin
         mode_ff     <= mode_in;
         lit_left_ff <= lit_left_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

### hw/rtl/prd_queue.sv
// ----------------------------------------------------------------------------
// prd_queue
// Short FIFO between front and back so that each side can stall on its own.
// ----------------------------------------------------------------------------
module prd_queue
   import prd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  prd_entry_type push_entry,
   output logic          push_ready,
   input  logic          pop,
   output logic          pop_valid,
   output prd_entry_type pop_entry
);

   prd_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != QCNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

### hw/rtl/prd_back.sv
// ----------------------------------------------------------------------------
// prd_back
// Back end: owns the output limit, counts decoded bytes, clips the run that
// reaches the limit and holds the result in an output register.
// ----------------------------------------------------------------------------
module prd_back
   import prd_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [15:0]   csr_output_limit,
   input  logic          q_valid,
   input  prd_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_pixel_value,
   output logic [7:0]    rsp_repeat_count,
   output logic          rsp_limit_reached
);

   localparam int WIDE = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 1;

   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;
   logic                   finished_ff, finished_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             pixel_ff, pixel_in;
   logic [7:0]             repeat_ff, repeat_in;
   logic                   reached_ff, reached_in;

   logic [WIDE-1:0]        bytes_ext, limit_ext, remaining, run_ext, new_ext;
   logic                   under_limit;
   logic [7:0]             clipped;
   logic [COUNT_WIDTH:0]   sum;
   logic [COUNT_WIDTH-1:0] bytes_sat;
   logic                   load;

   assign csr_ready = 1'b1;

   // Limit arithmetic
   assign bytes_ext   = WIDE'(bytes_ff);
   assign limit_ext   = WIDE'(limit_ff);
   assign run_ext     = WIDE'(q_entry.run);
   assign under_limit = bytes_ext < limit_ext;
   assign remaining   = limit_ext - bytes_ext;
   assign clipped     = (run_ext > remaining) ? remaining[7:0] : q_entry.run;
   assign sum         = {1'b0, bytes_ff} + (COUNT_WIDTH+1)'(clipped);
   // counter saturates at all ones
   assign bytes_sat   = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
   assign new_ext     = WIDE'(bytes_sat);

   // One queue item per cycle whenever the output register is free
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);
   assign load  = q_pop && q_entry.is_data && !finished_ff && under_limit;

   // Decode state and result
   always_comb begin
      limit_in    = limit_ff;
      bytes_in    = bytes_ff;
      finished_in = finished_ff;
      pixel_in    = pixel_ff;
      repeat_in   = repeat_ff;
      reached_in  = reached_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_output_limit;
      end
      if (q_pop) begin
         if (!q_entry.is_data) begin
            // start marker
            bytes_in    = '0;
            finished_in = 1'b0;
         end else if (!finished_ff) begin
            if (!under_limit) begin
               finished_in = 1'b1;
            end else begin
               bytes_in    = bytes_sat;
               finished_in = new_ext >= limit_ext;
               pixel_in    = q_entry.value;
               repeat_in   = clipped;
               reached_in  = new_ext >= limit_ext;
            end
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         bytes_ff     <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         bytes_ff     <= bytes_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      pixel_ff   <= pixel_in;
      repeat_ff  <= repeat_in;
      reached_ff <= reached_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_value   = pixel_ff;
   assign rsp_repeat_count  = repeat_ff;
   assign rsp_limit_reached = reached_ff;

   a_nonzero_run: assert property (@(posedge clock) disable iff (reset)
      load |-> clipped != 8'd0)
      else $error("result with zero repeat count");
   a_flag_sets_done: assert property (@(posedge clock) disable iff (reset)
      (load && reached_in) |=> finished_ff && rsp_valid_ff)
      else $error("limit flag without finished state");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (finished_ff && !(q_pop && !q_entry.is_data)) |=> finished_ff)
      else $error("finished cleared without start marker");
   a_no_load_done: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !load)
      else $error("result produced after finishing");

endmodule

### hw/rtl/packbits_run_decoder.sv
// ----------------------------------------------------------------------------
// packbits_run_decoder
// Run-length byte stream decoder: one compressed byte per item, one result
// per data byte below the limit, carrying the value, its clipped repeat count and a limit flag.
// Throughput: one compressed byte per cycle while the queue has room and the
// result side keeps up; each accepted data byte passes through a queue slot
// and then the output register before its result appears.
// Reset: synchronous; mode header, counters zero, limit 64000, queue empty.
// ----------------------------------------------------------------------------
module packbits_run_decoder
   import prd_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_output_limit,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_start_image,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_value,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_limit_reached
);

   logic          push, push_ready, pop, pop_valid;
   prd_entry_type push_entry, pop_entry;

   // Framing parser
   prd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .req_start_image (req_start_image),
      .q_ready         (push_ready),
      .q_push          (push),
      .q_entry         (push_entry)
   );

   // Decoupling queue
   prd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Limit accounting and result register
   prd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_limit  (csr_output_limit),
      .q_valid           (pop_valid),
      .q_entry           (pop_entry),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_limit_reached (rsp_limit_reached)
   );

endmodule

### verif/packbits_run_decoder_tb.sv
// ----------------------------------------------------------------------------
// packbits_run_decoder_tb
// Self-checking bench for the run-length byte decoder. A tracker class
// follows the decoder state and queues the expected runs for every accepted
// byte. A monitor compares each accepted result with the oldest queued run.
// The stimulus is a directed sequence for restarts, clipping, a zero limit
// and a limit lowered mid-image. Random images follow under several limits,
// with random idle bursts on both channels except in the final stretch.
// ----------------------------------------------------------------------------
module packbits_run_decoder_tb
   import prd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_output_limit;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_stream_byte;
   logic        req_start_image;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_pixel_value;
   logic [7:0]  rsp_repeat_count;
   logic        rsp_limit_reached;

   // one decoded run as the result channel carries it
   typedef struct {
      logic [7:0] value;
      logic [7:0] count;
      logic       at_limit;
   } decoded_run_type;

   // Tracks decoder state and holds the runs still due on the result side
   class run_decode_tracker;
      logic [15:0]     limit;
      prd_mode_type    mode;
      logic [7:0]      literals_left;
      logic [7:0]      repeat_len;
      logic [15:0]     written;
      bit              finished;
      decoded_run_type runs_due[$];
      int              errors;

      function new();
         limit         = LIMIT_RESET;
         mode          = MODE_HEADER;
         literals_left = '0;
         repeat_len    = '0;
         written       = '0;
         finished      = 1'b0;
         errors        = 0;
      endfunction

      function int pending();
         return runs_due.size();
      endfunction

      // data byte written 'run' times, clipped at the limit
      function void emit_run(logic [7:0] value, logic [7:0] run);
         int unsigned     room;
         int unsigned     n;
         int unsigned     sum;
         decoded_run_type r;
         if (written >= limit) begin
            // limit already passed: nothing out, decoder stops
            finished = 1'b1;
            mode     = MODE_HEADER;
            return;
         end
         room = limit - written;
         n    = (run > room) ? room : run;
         sum  = written + n;
         written    = (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
         r.value    = value;
         r.count    = n[7:0];
         r.at_limit = 1'b0;
         if (written >= limit) begin
            r.at_limit    = 1'b1;
            finished      = 1'b1;
            mode          = MODE_HEADER;
            literals_left = '0;
            repeat_len    = '0;
         end
         runs_due.push_back(r);
      endfunction

      // accepted input byte; ignored after finishing until a start
      function void take_byte(logic [7:0] b, logic start);
         if (start) begin
            written       = '0;
            finished      = 1'b0;
            mode          = MODE_HEADER;
            literals_left = '0;
            repeat_len    = '0;
         end
         if (finished)
            return;
         case (mode)
            MODE_REPEAT: begin
               mode = MODE_HEADER;
               emit_run(b, repeat_len);
            end
            MODE_LITERAL: begin
               literals_left = literals_left - 8'd1;
               if (literals_left == 8'd0)
                  mode = MODE_HEADER;
               emit_run(b, 8'd1);
            end
            default: begin
               if (b > HEADER_SPLIT) begin
                  repeat_len = 8'(REPEAT_BASE - {1'b0, b});
                  mode       = MODE_REPEAT;
               end else begin
                  literals_left = b + 8'd1;
                  mode          = MODE_LITERAL;
               end
            end
         endcase
      endfunction

      // accepted result against the oldest run due
      function void check_run(logic [7:0] value, logic [7:0] count, logic at_limit);
         decoded_run_type e;
         if (runs_due.size() == 0) begin
            $error("unexpected result: pixel_value %0d repeat_count %0d limit_reached %0b",
                   value, count, at_limit);
            errors++;
            return;
         end
         e = runs_due.pop_front();
         if (value !== e.value) begin
            $error("pixel_value: expected %0d, actual %0d", e.value, value);
            errors++;
         end
         if (count !== e.count) begin
            $error("repeat_count: expected %0d, actual %0d", e.count, count);
            errors++;
         end
         if (at_limit !== e.at_limit) begin
            $error("limit_reached: expected %0b, actual %0b", e.at_limit, at_limit);
            errors++;
         end
      endfunction
   endclass

   run_decode_tracker sb;
   bit                no_idle;
   int                sent_items;

   packbits_run_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_limit  (csr_output_limit),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_byte   (req_stream_byte),
      .req_start_image   (req_start_image),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_limit_reached (rsp_limit_reached)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   initial begin
      #3ms;
      $display("packbits_run_decoder_tb failed");
      $finish;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_run(rsp_pixel_value, rsp_repeat_count, rsp_limit_reached);
   end

   // result backpressure: stall bursts with calm stretches between
   initial begin
      int hold_left;
      int calm_left;
      hold_left = 0;
      calm_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset || no_idle) begin
            rsp_ready = 1'b1;
         end else if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (calm_left > 0) begin
            rsp_ready = 1'b1;
            calm_left--;
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  rsp_ready = 1'b0;
                  hold_left = $urandom_range(0, 5);
               end
               1: begin
                  rsp_ready = 1'b1;
                  calm_left = $urandom_range(10, 40);
               end
               default: rsp_ready = 1'b1;
            endcase
         end
      end
   end

   // one compressed byte; called and returns at a falling edge, valid left high
   task automatic send_item(input logic [7:0] b, input logic start);
      int gap;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap       = $urandom_range(1, 6);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_stream_byte = b;
      req_start_image = start;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.take_byte(b, start);
      sent_items++;
      @(negedge clock);
   endtask

   // drain all results, then write the output limit
   task automatic write_limit(input logic [15:0] value);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_valid        = 1'b1;
      csr_output_limit = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.limit = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one packet: mostly well formed, sometimes a stray byte or restart
   task automatic send_packet(input logic first);
      int         kind;
      int         n;
      logic [7:0] hdr;
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
         hdr = 8'($urandom_range(8'h81, 8'hFF));
         send_item(hdr, first);
         send_item(8'($urandom), 1'b0);
      end else if (kind < 17) begin
         n = $urandom_range(0, 7);
         send_item(8'(n), first);
         repeat (n + 1) send_item(8'($urandom), 1'b0);
      end else if (kind == 17) begin
         hdr = ($urandom_range(0, 1) != 0) ? HEADER_SPLIT : 8'($urandom_range(8, 127));
         send_item(hdr, first);
         repeat (int'(hdr) + 1) send_item(8'($urandom), 1'b0);
      end else begin
         send_item(8'($urandom), first || ($urandom_range(0, 3) == 0));
      end
   endtask

   // random images until 'quota' more bytes were sent
   task automatic run_images(input int quota);
      int stop;
      stop = sent_items + quota;
      while (sent_items < stop) begin
         send_packet(1'b1);
         while (!sb.finished && sent_items < stop && $urandom_range(0, 30) != 0)
            send_packet(1'b0);
      end
   endtask

   // main sequence
   initial begin
      sb               = new();
      no_idle          = 1'b0;
      sent_items       = 0;
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_output_limit = '0;
      req_valid        = 1'b0;
      req_stream_byte  = '0;
      req_start_image  = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // decoding straight from reset, header extremes
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h81, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hA5, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h11, 1'b0);
      send_item(8'h22, 1'b0);
      // restart inside a literal run, then inside a repeat
      send_item(8'h7F, 1'b1);
      send_item(8'h33, 1'b0);
      send_item(8'hC0, 1'b1);
      send_item(8'h5A, 1'b1);
      send_item(8'h44, 1'b0);

      // clipped run, then bytes ignored until the next start
      write_limit(16'd5);
      send_item(8'h83, 1'b1);
      send_item(8'h99, 1'b0);
      send_item(8'h10, 1'b0);
      send_item(8'h20, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h77, 1'b0);

      // zero limit: data is dropped and the decoder stops
      write_limit(16'd0);
      send_item(8'h00, 1'b1);
      send_item(8'hEE, 1'b0);
      send_item(8'h01, 1'b0);

      // limit lowered below the count mid-image
      write_limit(16'hFFFF);
      send_item(8'hC0, 1'b1);
      send_item(8'h01, 1'b0);
      send_item(8'h05, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'h03, 1'b0);
      write_limit(16'd10);
      send_item(8'h04, 1'b0);
      send_item(8'h05, 1'b0);

      // random images under several limits
      write_limit(16'hFFFF);
      run_images(250);
      write_limit(16'd1);
      run_images(100);
      write_limit(16'($urandom_range(20, 400)));
      run_images(250);
      write_limit(16'd0);
      run_images(50);
      write_limit(LIMIT_RESET);
      run_images(300);
      // final stretch at full rate
      write_limit(16'($urandom_range(2, 200)));
      no_idle = 1'b1;
      run_images(150);

      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (sb.errors == 0)
         $display("packbits_run_decoder_tb passed");
      else
         $display("packbits_run_decoder_tb failed");
      $finish;
   end

endmodule
